// ===== hw/rtl/cap_pkg.sv =====
`default_nettype none
package cap_pkg;

	localparam int FieldW = 24;
	localparam int FdW    = 40;
	localparam int IntW   = 40;
	localparam int MulAW  = 26;
	localparam int MulBW  = 24;
	localparam int ProdW  = 51;
	localparam int AccW   = 66;
	localparam int DriveW = 16;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_ANGLE_GAIN     = 3'd0,
		REG_RATE_LIMIT     = 3'd1,
		REG_RATE_KP        = 3'd2,
		REG_RATE_KI_DT     = 3'd3,
		REG_RATE_KD        = 3'd4,
		REG_LPF_GAIN       = 3'd5,
		REG_INTEGRAL_LIMIT = 3'd6,
		REG_OUTPUT_LIMIT   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] angle_gain;
		logic [22:0] rate_limit;
		logic [23:0] rate_kp;
		logic [23:0] rate_ki_dt;
		logic [23:0] rate_kd;
		logic [15:0] lpf_gain;
		logic [22:0] integral_limit;
		logic [14:0] output_limit;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_ANG,
		ST_MUL_DLO,
		ST_MUL_DHI,
		ST_MUL_P,
		ST_MUL_I,
		ST_MUL_FLO,
		ST_MUL_FHI,
		ST_SUM_D,
		ST_SUM_ALL,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MS_ANGLE,
		MS_DLO,
		MS_DHI,
		MS_P,
		MS_I,
		MS_FLO,
		MS_FHI
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     cap;
		logic     ld_dx;
		logic     ld_re;
		logic     acc_ld;
		logic     acc_add_hi;
		logic     fd_upd;
		logic     sum_ld;
		logic     int_upd;
		logic     sum_add_int;
		logic     sum_add_acc;
		logic     out_ld;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cap_regs.sv =====
`default_nettype none
module cap_regs import cap_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [23:0]        cfg_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_gain     <= 24'd65536;
			cfg_q.rate_limit     <= 23'd25600;
			cfg_q.rate_kp        <= 24'd65536;
			cfg_q.rate_ki_dt     <= 24'd131;
			cfg_q.rate_kd        <= 24'd0;
			cfg_q.lpf_gain       <= 16'd28174;
			cfg_q.integral_limit <= 23'd51200;
			cfg_q.output_limit   <= 15'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ANGLE_GAIN:     cfg_q.angle_gain     <= cfg_data;
				REG_RATE_LIMIT:     cfg_q.rate_limit     <= cfg_data[22:0];
				REG_RATE_KP:        cfg_q.rate_kp        <= cfg_data;
				REG_RATE_KI_DT:     cfg_q.rate_ki_dt     <= cfg_data;
				REG_RATE_KD:        cfg_q.rate_kd        <= cfg_data;
				REG_LPF_GAIN:       cfg_q.lpf_gain       <= cfg_data[15:0];
				REG_INTEGRAL_LIMIT: cfg_q.integral_limit <= cfg_data[22:0];
				REG_OUTPUT_LIMIT:   cfg_q.output_limit   <= cfg_data[14:0];
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/cap_ctrl.sv =====
`default_nettype none
module cap_ctrl import cap_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		cmd      = '0;
		cmd.mul_sel = MS_ANGLE;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = ST_MUL_ANG;
				end
			end
			ST_MUL_ANG: begin
				cmd.mul_sel = MS_ANGLE;
				cmd.ld_dx   = 1'b1;
				state_d     = ST_MUL_DLO;
			end
			ST_MUL_DLO: begin
				cmd.mul_sel = MS_DLO;
				cmd.ld_re   = 1'b1;
				state_d     = ST_MUL_DHI;
			end
			ST_MUL_DHI: begin
				cmd.mul_sel = MS_DHI;
				cmd.acc_ld  = 1'b1;
				state_d     = ST_MUL_P;
			end
			ST_MUL_P: begin
				cmd.mul_sel    = MS_P;
				cmd.acc_add_hi = 1'b1;
				state_d        = ST_MUL_I;
			end
			ST_MUL_I: begin
				cmd.mul_sel = MS_I;
				cmd.fd_upd  = 1'b1;
				cmd.sum_ld  = 1'b1;
				state_d     = ST_MUL_FLO;
			end
			ST_MUL_FLO: begin
				cmd.mul_sel = MS_FLO;
				cmd.int_upd = 1'b1;
				state_d     = ST_MUL_FHI;
			end
			ST_MUL_FHI: begin
				cmd.mul_sel     = MS_FHI;
				cmd.acc_ld      = 1'b1;
				cmd.sum_add_int = 1'b1;
				state_d         = ST_SUM_D;
			end
			ST_SUM_D: begin
				cmd.acc_add_hi = 1'b1;
				state_d        = ST_SUM_ALL;
			end
			ST_SUM_ALL: begin
				cmd.sum_add_acc = 1'b1;
				state_d         = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == ST_MUL_ANG)
		else $error("accepted transaction did not start the sequence");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> status.out_free)
		else $error("result loaded while output register occupied");

	a_idle_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(cmd.ld_re || cmd.fd_upd || cmd.int_upd || cmd.out_ld))
		else $error("datapath state updated while idle");

endmodule
`default_nettype wire

// ===== hw/rtl/cap_datapath.sv =====
`default_nettype none
module cap_datapath import cap_pkg::*; #(
	parameter int LOOP_RATE_HZ = 250
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cmd_t                     cmd,
	output status_t                       status,
	input  wire cfg_t                     cfg,
	input  wire logic signed [FieldW-1:0] target_angle,
	input  wire logic signed [FieldW-1:0] measured_angle,
	input  wire logic signed [FieldW-1:0] measured_rate,
	input  wire logic                     out_stall,
	output logic                          out_valid,
	output logic signed [DriveW-1:0]      drive
);

	localparam int RateW = $clog2(LOOP_RATE_HZ + 1);
	localparam int XW = RateW + 26;
	localparam logic signed [RateW:0] RateK = (RateW + 1)'(LOOP_RATE_HZ);
	localparam logic signed [AccW-1:0] TruncBias = 66'sh0FFFFFF;

	logic signed [24:0]        e_q;
	logic signed [FieldW-1:0]  rate_q;
	logic signed [FieldW-1:0]  prev_q;
	logic signed [XW-1:0]      x_q;
	logic signed [FdW:0]       dx_q;
	logic signed [24:0]        re_q;
	logic signed [ProdW-1:0]   prod_q;
	logic signed [AccW-1:0]    acc_q;
	logic signed [AccW-1:0]    sum_q;
	logic signed [FdW-1:0]     fd_q;
	logic signed [IntW-1:0]    int_q;
	logic signed [DriveW-1:0]  drive_q;
	logic                      out_valid_q;

	logic signed [24:0]        rate_diff;
	logic signed [XW-1:0]      x_d;
	logic signed [FdW:0]       dx_d;
	logic signed [MulAW-1:0]   mul_a;
	logic [MulBW-1:0]          mul_b;
	logic signed [ProdW-1:0]   prod_d;
	logic signed [ProdW-1:0]   ang_lim;
	logic signed [ProdW-1:0]   dq;
	logic signed [24:0]        re_d;
	logic signed [51:0]        int_sum;
	logic signed [51:0]        int_lim;
	logic signed [51:0]        int_c;
	logic signed [FdW-1:0]     fd_d;
	logic signed [AccW-1:0]    trunc_w;
	logic signed [41:0]        q_int;
	logic signed [41:0]        out_lim;
	logic signed [DriveW-1:0]  drive_d;

	assign rate_diff = 25'(measured_rate) - 25'(prev_q);
	assign x_d  = XW'(rate_diff) * XW'(RateK);
	assign dx_d = (FdW + 1)'(x_q) - (FdW + 1)'(fd_q);

	// shared multiplier; wide operands go through in two halves
	always_comb begin
		case (cmd.mul_sel)
			MS_ANGLE: begin
				mul_a = MulAW'(e_q);
				mul_b = cfg.angle_gain;
			end
			MS_DLO: begin
				mul_a = $signed({6'd0, dx_q[19:0]});
				mul_b = {8'd0, cfg.lpf_gain};
			end
			MS_DHI: begin
				mul_a = MulAW'($signed(dx_q[40:20]));
				mul_b = {8'd0, cfg.lpf_gain};
			end
			MS_P: begin
				mul_a = MulAW'(re_q);
				mul_b = cfg.rate_kp;
			end
			MS_I: begin
				mul_a = MulAW'(re_q);
				mul_b = cfg.rate_ki_dt;
			end
			MS_FLO: begin
				mul_a = $signed({6'd0, fd_q[19:0]});
				mul_b = cfg.rate_kd;
			end
			MS_FHI: begin
				mul_a = MulAW'($signed(fd_q[39:20]));
				mul_b = cfg.rate_kd;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = ProdW'(mul_a) * ProdW'($signed({1'b0, mul_b}));

	// demanded rate: clamp, then floor to Q.8
	assign ang_lim = $signed({12'd0, cfg.rate_limit, 16'd0});
	always_comb begin
		if (prod_q > ang_lim) begin
			dq = ang_lim;
		end else if (prod_q < -ang_lim) begin
			dq = -ang_lim;
		end else begin
			dq = prod_q;
		end
	end
	assign re_d = 25'($signed(dq[39:16])) - 25'(rate_q);

	assign int_sum = 52'(int_q) + 52'(prod_q);
	assign int_lim = $signed({13'd0, cfg.integral_limit, 16'd0});
	always_comb begin
		if (int_sum > int_lim) begin
			int_c = int_lim;
		end else if (int_sum < -int_lim) begin
			int_c = -int_lim;
		end else begin
			int_c = int_sum;
		end
	end

	// filter step stays inside 40 bits, so the add may wrap
	assign fd_d = fd_q + $signed(acc_q[55:16]);

	// truncate toward zero, then saturate
	assign trunc_w = (sum_q + (sum_q[AccW-1] ? TruncBias : '0)) >>> 24;
	assign q_int   = $signed(trunc_w[41:0]);
	assign out_lim = $signed({27'd0, cfg.output_limit});
	always_comb begin
		if (q_int > out_lim) begin
			drive_d = out_lim[DriveW-1:0];
		end else if (q_int < -out_lim) begin
			drive_d = DriveW'(-out_lim);
		end else begin
			drive_d = q_int[DriveW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.cap) begin
			e_q    <= 25'(target_angle) - 25'(measured_angle);
			rate_q <= measured_rate;
			x_q    <= x_d;
		end
		if (cmd.ld_dx) begin
			dx_q <= dx_d;
		end
		if (cmd.ld_re) begin
			re_q <= re_d;
		end
		if (cmd.acc_ld) begin
			acc_q <= AccW'(prod_q);
		end else if (cmd.acc_add_hi) begin
			acc_q <= acc_q + (AccW'(prod_q) <<< 20);
		end
		if (cmd.sum_ld) begin
			sum_q <= AccW'(prod_q);
		end else if (cmd.sum_add_int) begin
			sum_q <= sum_q + AccW'(int_q);
		end else if (cmd.sum_add_acc) begin
			sum_q <= sum_q + acc_q;
		end
		if (cmd.out_ld) begin
			drive_q <= drive_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= '0;
			fd_q        <= '0;
			int_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cap) begin
				prev_q <= measured_rate;
			end
			if (cmd.fd_upd) begin
				fd_q <= fd_d;
			end
			if (cmd.int_upd) begin
				int_q <= int_c[IntW-1:0];
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign drive = drive_q;

	a_drop_only_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(!out_stall))
		else $error("result dropped before the transaction completed");

endmodule
`default_nettype wire

// ===== hw/rtl/cascaded_angle_rate_pid.sv =====
// After an input is accepted, one shared 26x25 multiplier runs seven products
// in sequence, wide filter and derivative products in halves, then two sums;
// drive loads in DONE once the output is free, and only then is input taken.
// Reset (arst_n low, asynchronous): registers return to their default values,
// integral, filter and previous rate clear to zero, no result pending.
`default_nettype none
module cascaded_angle_rate_pid import cap_pkg::*; #(
	parameter int LOOP_RATE_HZ = 250
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [FieldW-1:0] target_angle,
	input  wire logic signed [FieldW-1:0] measured_angle,
	input  wire logic signed [FieldW-1:0] measured_rate,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DriveW-1:0]      drive,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CfgIdxW-1:0]       cfg_index,
	input  wire logic [23:0]              cfg_data
);

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	cap_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	cap_datapath #(
		.LOOP_RATE_HZ (LOOP_RATE_HZ)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg            (cfg),
		.target_angle   (target_angle),
		.measured_angle (measured_angle),
		.measured_rate  (measured_rate),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.drive          (drive)
	);

endmodule
`default_nettype wire
